// ===== rtl/rotary_encoder_accel_decoder_defines.svh =====
// Assertion macros shared by the rotary encoder decoder RTL.
// Expects aclk and aresetn in the scope of each use.
`ifndef ROTARY_ENCODER_ACCEL_DECODER_DEFINES_SVH
`define ROTARY_ENCODER_ACCEL_DECODER_DEFINES_SVH

// Same-cycle implication.
`define REA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rea assertion failed");

// Next-cycle implication.
`define REA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rea assertion failed");

`endif

// ===== rtl/rea_pkg.sv =====
// Types and constants for the rotary encoder decoder.
// No dependencies; imported by every RTL module of the block.
package rea_pkg;

    localparam int REA_MAX_SPEED   = 10;
    localparam int REA_QUEUE_DEPTH = 2;

    localparam int TIME_W  = 32;
    localparam int AMT_W   = 7;
    localparam int SPEED_W = 8;
    localparam int MULT_W  = 12;
    localparam int CFG_W   = 12;

    typedef enum logic [1:0] {
        ACT_ROTATE = 2'd0,
        ACT_SWITCH = 2'd1,
        ACT_READ   = 2'd2
    } rea_act_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } rea_dir_t;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_STEP = 2'd1,
        OP_READ = 2'd2
    } rea_op_t;

    typedef enum logic [1:0] {
        CFG_VSE        = 2'd0,
        CFG_SPEED_DOWN = 2'd1,
        CFG_SPEED_UP   = 2'd2,
        CFG_MULT       = 2'd3
    } rea_cfg_idx_t;

    typedef struct packed {
        logic [1:0]        action;
        logic              pin_a;
        logic              pin_b;
        logic              switch_level;
        logic [TIME_W-1:0] time_us;
    } rea_in_t;

    typedef struct packed {
        logic [1:0]        step_direction;
        logic [AMT_W-1:0]  step_amount;
        logic signed [31:0] count_value;
        logic              clicked;
    } rea_out_t;

    // Classified request from the front end to the back end.
    typedef struct packed {
        rea_op_t           op;
        rea_dir_t          dir;
        logic [TIME_W-1:0] delta;
        logic              clicked;
    } rea_cmd_t;

    typedef struct packed {
        logic               start;
        logic [TIME_W-1:0]  delta;
        logic [SPEED_W-1:0] speed;
        logic [MULT_W-1:0]  mult;
    } rea_acc_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [AMT_W-1:0] amount;
    } rea_acc_rsp_t;

endpackage

// ===== rtl/rea_front.sv =====
// Front end: accepts requests, runs the half-step table, switch timing and click flag.
// Depends on rea_pkg; feeds classified requests into rea_fifo.
module rea_front
    import rea_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rea_in_t  s_data,
    input  logic     q_full,
    output logic     q_push,
    output rea_cmd_t q_data
);

    localparam logic [7:0] CODE_CW  = 8'h20;
    localparam logic [7:0] CODE_CCW = 8'h10;
    localparam logic [TIME_W-1:0] CLICK_MIN = 32'd10000;
    localparam logic [TIME_W-1:0] CLICK_MAX = 32'd250000;

    localparam logic [7:0] STEP_TBL [6][4] = '{
        '{8'h03, 8'h02, 8'h01, 8'h00},
        '{8'h23, 8'h00, 8'h01, 8'h00},
        '{8'h13, 8'h02, 8'h00, 8'h00},
        '{8'h03, 8'h05, 8'h04, 8'h00},
        '{8'h03, 8'h03, 8'h04, 8'h10},
        '{8'h03, 8'h05, 8'h03, 8'h20}
    };

    logic [2:0]        table_state_reg;
    logic [TIME_W-1:0] last_step_reg;
    logic [TIME_W-1:0] last_press_reg;
    logic              click_reg;

    logic [2:0]        row_idx;
    logic [1:0]        col;
    logic [7:0]        code;
    logic              is_step;
    logic [TIME_W-1:0] press_delta;
    logic              click_ok;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    assign row_idx     = (table_state_reg > 3'd5) ? 3'd0 : table_state_reg;
    assign col         = {s_data.pin_b, s_data.pin_a};
    assign code        = STEP_TBL[row_idx][col];
    assign is_step     = (code == CODE_CW) || (code == CODE_CCW);
    assign press_delta = s_data.time_us - last_press_reg;
    assign click_ok    = (press_delta > CLICK_MIN) && (press_delta < CLICK_MAX);

    always_comb begin
        q_data.op      = OP_NONE;
        q_data.dir     = DIR_NONE;
        q_data.delta   = s_data.time_us - last_step_reg;
        q_data.clicked = 1'b0;
        unique case (rea_act_t'(s_data.action))
            ACT_ROTATE: begin
                if (is_step) begin
                    q_data.op  = OP_STEP;
                    q_data.dir = (code == CODE_CW) ? DIR_CW : DIR_CCW;
                end
            end
            ACT_READ: begin
                q_data.op      = OP_READ;
                q_data.clicked = click_reg;
            end
            default: q_data.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_state_reg <= 3'd0;
            last_step_reg   <= '0;
            last_press_reg  <= '0;
            click_reg       <= 1'b0;
        end else if (q_push) begin
            unique case (rea_act_t'(s_data.action))
                ACT_ROTATE: begin
                    table_state_reg <= code[2:0];
                    if (is_step) begin
                        last_step_reg <= s_data.time_us;
                    end
                end
                ACT_SWITCH: begin
                    if (s_data.switch_level) begin
                        if (click_ok) begin
                            click_reg <= 1'b1;
                        end
                    end else begin
                        last_press_reg <= s_data.time_us;
                    end
                end
                ACT_READ: click_reg <= 1'b0;
                default:  click_reg <= click_reg;
            endcase
        end
    end

endmodule

// ===== rtl/rea_fifo.sv =====
// Short request queue between front end and back end.
// Depends on rea_pkg for the request type.
`include "rotary_encoder_accel_decoder_defines.svh"
module rea_fifo
    import rea_pkg::*;
#(
    parameter int DEPTH = REA_QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  rea_cmd_t push_data,
    output logic     full,
    input  logic     pop,
    output rea_cmd_t pop_data,
    output logic     empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rea_cmd_t          mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    `REA_ASSERT_IMPL(a_fifo_cnt_bound, 1'b1, cnt_reg <= CNT_W'(DEPTH))

endmodule

// ===== rtl/rea_accel.sv =====
// Step-size unit: linear time remap, Q4.8 scale, clamp and round half up.
// Depends on rea_pkg; split multiply, then a reciprocal multiply with one correction.
`include "rotary_encoder_accel_decoder_defines.svh"
module rea_accel
    import rea_pkg::*;
#(
    parameter int MAX_SPEED = REA_MAX_SPEED
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  rea_acc_req_t req,
    output rea_acc_rsp_t rsp
);

    // amount = m * n / DEN, n = 24500000*S + (d - 5000)*(MAX - 100*S)
    localparam longint unsigned DEN = 64'd62720000 * 64'(MAX_SPEED);
    localparam longint unsigned LIM = 64'd100 * DEN;
    localparam longint unsigned DV  = 64'd2 * DEN;
    localparam int NW   = $clog2(LIM);
    localparam int LOW  = NW / 2;
    localparam int PLW  = LOW + MULT_W;
    localparam int PW   = NW + MULT_W;
    localparam int XW   = $clog2(64'd256 * DEN);
    localparam int KW   = 17;
    localparam int DKW  = TIME_W + 1 + KW;
    localparam int NFW  = DKW + 2;
    // quotient estimate: (x >> SH) * floor(2^KQ / DV) >> (KQ - SH), low by at most one
    localparam int SH   = $clog2(DV) - 3;
    localparam int KQ   = XW + 2;
    localparam int QS   = KQ - SH;
    localparam int XSW  = XW - SH;
    localparam int QPW  = 2 * XSW;
    localparam longint unsigned RCP = (64'd1 << KQ) / DV;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_SUMN, ST_MLO, ST_MHI, ST_CLAS, ST_QEST, ST_QFIX, ST_DONE
    } state_t;

    state_t               state_reg;
    logic [TIME_W-1:0]    delta_reg;
    logic [SPEED_W-1:0]   speed_reg;
    logic [MULT_W-1:0]    mult_reg;
    logic signed [DKW-1:0] dk_reg;
    logic signed [NFW-1:0] base_reg;
    logic signed [NFW-1:0] n_reg;
    logic                 n_neg_reg;
    logic                 n_big_reg;
    logic [PLW-1:0]       plo_reg;
    logic [PW-1:0]        p_reg;
    logic [XW-1:0]        x_reg;
    logic [AMT_W-1:0]     q_reg;
    logic [AMT_W-1:0]     amt_reg;

    logic signed [KW-1:0]  k_w;
    logic signed [DKW-1:0] dk_w;
    logic [NFW-1:0]        sp_base_w;
    logic signed [NFW-1:0] k5_w;
    logic [NW-1:0]         nc;
    logic [PLW-1:0]        plo_w;
    logic [PW-1:0]         phi_w;
    logic [QPW-1:0]        qp_w;
    logic [XW-1:0]         thr_w;
    logic                  ge;

    assign k_w       = $signed(KW'(MAX_SPEED)) - $signed({2'b00, 15'(speed_reg) * 15'd100});
    assign dk_w      = $signed({1'b0, delta_reg}) * k_w;
    assign sp_base_w = NFW'(speed_reg) * NFW'(64'd24500000);
    assign k5_w      = NFW'(k_w) * $signed(NFW'(5000));
    assign nc        = n_reg[NW-1:0];
    assign plo_w     = PLW'(mult_reg) * PLW'(nc[LOW-1:0]);
    assign phi_w     = PW'(mult_reg) * PW'(nc[NW-1:LOW]);
    // reciprocal fits in the same width as the scaled operand
    assign qp_w      = QPW'(x_reg[XW-1:SH]) * QPW'(XSW'(RCP));
    assign thr_w     = XW'((64'(q_reg) + 64'd1) * DV);
    assign ge        = (x_reg >= thr_w);

    assign rsp.busy   = (state_reg != ST_IDLE);
    assign rsp.done   = (state_reg == ST_DONE);
    assign rsp.amount = amt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (req.start) begin
                        delta_reg <= req.delta;
                        speed_reg <= req.speed;
                        mult_reg  <= req.mult;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    dk_reg    <= dk_w;
                    base_reg  <= $signed(sp_base_w) - k5_w;
                    state_reg <= ST_SUMN;
                end
                ST_SUMN: begin
                    n_reg     <= base_reg + NFW'(dk_reg);
                    state_reg <= ST_MLO;
                end
                ST_MLO: begin
                    n_neg_reg <= n_reg[NFW-1] || (n_reg == '0);
                    n_big_reg <= (n_reg >= $signed(NFW'(LIM)));
                    plo_reg   <= plo_w;
                    state_reg <= ST_MHI;
                end
                ST_MHI: begin
                    p_reg     <= PW'(plo_reg) + (phi_w << LOW);
                    state_reg <= ST_CLAS;
                end
                ST_CLAS: begin
                    if (n_neg_reg || (mult_reg == '0)) begin
                        amt_reg   <= AMT_W'(1);
                        state_reg <= ST_DONE;
                    end else if (n_big_reg || (p_reg >= PW'(LIM))) begin
                        amt_reg   <= AMT_W'(100);
                        state_reg <= ST_DONE;
                    end else if (p_reg <= PW'(DEN)) begin
                        amt_reg   <= AMT_W'(1);
                        state_reg <= ST_DONE;
                    end else begin
                        x_reg     <= XW'({p_reg, 1'b0}) + XW'(DEN);
                        state_reg <= ST_QEST;
                    end
                end
                ST_QEST: begin
                    q_reg     <= AMT_W'(qp_w >> QS);
                    state_reg <= ST_QFIX;
                end
                ST_QFIX: begin
                    amt_reg   <= q_reg + AMT_W'(ge);
                    state_reg <= ST_DONE;
                end
                ST_DONE: state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `REA_ASSERT_IMPL(a_acc_start_idle, req.start, state_reg == ST_IDLE)
    `REA_ASSERT_IMPL(a_acc_amt_range, rsp.done, (amt_reg >= AMT_W'(1)) && (amt_reg <= AMT_W'(100)))

endmodule

// ===== rtl/rea_back.sv =====
// Back end: configuration registers, rotation count and the result register.
// Depends on rea_pkg; drains rea_fifo and drives rea_accel.
`include "rotary_encoder_accel_decoder_defines.svh"
module rea_back
    import rea_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               q_empty,
    output logic               q_pop,
    input  rea_cmd_t           q_data,
    output rea_acc_req_t       acc_req,
    input  rea_acc_rsp_t       acc_rsp,
    output logic               m_valid,
    input  logic               m_ready,
    output rea_out_t           m_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_WAIT, ST_FINISH} state_t;

    state_t             state_reg;
    logic               vse_reg;
    logic [SPEED_W-1:0] spd_down_reg;
    logic [SPEED_W-1:0] spd_up_reg;
    logic [MULT_W-1:0]  mult_reg;
    logic [31:0]        count_reg;
    rea_cmd_t           cmd_reg;
    logic [AMT_W-1:0]   amt_reg;
    logic               m_valid_reg;
    rea_out_t           m_data_reg;

    logic               out_free;
    logic               fin_en;
    rea_cmd_t           fin_cmd;
    logic [AMT_W-1:0]   fin_amt;

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        acc_req.delta = q_data.delta;
        acc_req.speed = (q_data.dir == DIR_CW) ? spd_up_reg : spd_down_reg;
        acc_req.mult  = mult_reg;
        q_pop         = 1'b0;
        acc_req.start = 1'b0;
        fin_en        = 1'b0;
        fin_cmd       = cmd_reg;
        fin_amt       = amt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty && out_free) begin
                    q_pop = 1'b1;
                    if ((q_data.op == OP_STEP) && vse_reg) begin
                        acc_req.start = 1'b1;
                    end else begin
                        fin_en  = 1'b1;
                        fin_cmd = q_data;
                        fin_amt = (q_data.op == OP_STEP) ? AMT_W'(1) : '0;
                    end
                end
            end
            ST_WAIT:   fin_en = 1'b0;
            ST_FINISH: fin_en = out_free;
            default:   fin_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            vse_reg      <= 1'b1;
            spd_down_reg <= '0;
            spd_up_reg   <= '0;
            mult_reg     <= MULT_W'(256);
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (rea_cfg_idx_t'(cfg_index))
                    CFG_VSE:        vse_reg      <= cfg_data[0];
                    CFG_SPEED_DOWN: spd_down_reg <= cfg_data[SPEED_W-1:0];
                    CFG_SPEED_UP:   spd_up_reg   <= cfg_data[SPEED_W-1:0];
                    CFG_MULT:       mult_reg     <= cfg_data[MULT_W-1:0];
                    default:        vse_reg      <= vse_reg;
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (acc_req.start) begin
                        cmd_reg   <= q_data;
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (acc_rsp.done) begin
                        amt_reg   <= acc_rsp.amount;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (fin_en) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (fin_en) begin
                m_valid_reg                <= 1'b1;
                m_data_reg.step_direction  <= fin_cmd.dir;
                m_data_reg.step_amount     <= fin_amt;
                m_data_reg.count_value     <= (fin_cmd.op == OP_READ) ? $signed(count_reg) : '0;
                m_data_reg.clicked         <= (fin_cmd.op == OP_READ) && fin_cmd.clicked;
                case (fin_cmd.op)
                    OP_STEP: begin
                        if (fin_cmd.dir == DIR_CW) begin
                            count_reg <= count_reg + 32'(fin_amt);
                        end else begin
                            count_reg <= count_reg - 32'(fin_amt);
                        end
                    end
                    OP_READ: count_reg <= '0;
                    default: count_reg <= count_reg;
                endcase
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    `REA_ASSERT_NEXT(a_back_start_wait, acc_req.start, state_reg == ST_WAIT)
    `REA_ASSERT_IMPL(a_back_wait_busy, state_reg == ST_WAIT, acc_rsp.busy)

endmodule

// ===== rtl/rotary_encoder_accel_decoder.sv =====
// Rotary encoder decoder with time-based step acceleration and click detection.
// Every request yields one result. The front end takes a request per cycle while
// its queue has room; the back end pops a request once the output register is free
// and finishes one that needs no step-size arithmetic from its idle state; an accelerated
// step waits on the step-size unit (remap and split Q4.8 multiply, then a clamp, or a
// reciprocal multiply and one correction for rounding) and holds off the next request.
// Depends on rea_pkg, rea_front, rea_fifo, rea_accel and rea_back.
module rotary_encoder_accel_decoder
    import rea_pkg::*;
#(
    parameter int MAX_SPEED   = REA_MAX_SPEED,
    parameter int QUEUE_DEPTH = REA_QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  rea_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output rea_out_t         m_data
);

    logic         q_full;
    logic         q_push;
    rea_cmd_t     q_wdata;
    logic         q_empty;
    logic         q_pop;
    rea_cmd_t     q_rdata;
    rea_acc_req_t acc_req;
    rea_acc_rsp_t acc_rsp;

    rea_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_wdata)
    );

    rea_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    rea_accel #(
        .MAX_SPEED (MAX_SPEED)
    ) u_accel (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (acc_req),
        .rsp     (acc_rsp)
    );

    rea_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_data    (q_rdata),
        .acc_req   (acc_req),
        .acc_rsp   (acc_rsp),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== sim/rotary_encoder_accel_decoder_tb.sv =====
// Self-checking testbench for rotary_encoder_accel_decoder: directed table, then random
// detent sequences, switch clicks and reads under several configs and flow-control phases.
// Depends on rea_pkg and the block's RTL; results are checked against hand-written values and an in-bench predictor.
module rotary_encoder_accel_decoder_tb;
    import rea_pkg::*;

    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         HOLD_LEN      = 400;
    localparam int         PHASE_ITEMS   = 115;
    localparam int         TAIL_CYCLES   = 40;
    localparam logic [1:0] ACT_UNUSED    = 2'd3;
    localparam logic [7:0] CODE_CCW      = 8'h10;
    localparam logic [7:0] CODE_CW       = 8'h20;
    localparam longint     DEN           = 64'sd256 * 64'sd245000 * REA_MAX_SPEED;

    // half-step transition table, indexed [state][pin_b, pin_a]
    localparam logic [7:0] DETENT_TABLE [6][4] = '{
        '{8'h03, 8'h02, 8'h01, 8'h00}, '{8'h23, 8'h00, 8'h01, 8'h00},
        '{8'h13, 8'h02, 8'h00, 8'h00}, '{8'h03, 8'h05, 8'h04, 8'h00},
        '{8'h03, 8'h03, 8'h04, 8'h10}, '{8'h03, 8'h05, 8'h03, 8'h20}
    };

    typedef struct {
        rea_in_t  req;
        bit       typed;
        rea_out_t want;
    } dir_row_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [1:0]       cfg_index = CFG_VSE;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    rea_in_t          s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    rea_out_t         m_data;

    // predictor state and its copy of the registers
    logic [2:0]  enc_state;
    logic [31:0] count_acc;
    logic [31:0] prev_step_us;
    logic [31:0] press_us;
    logic        click_flag;
    logic        accel_on;
    logic [7:0]  spd_ccw;
    logic [7:0]  spd_cw;
    logic [11:0] mult_q48;

    rea_out_t    expected_results [$];
    int          cycle_count  = 0;
    int          mismatches   = 0;
    int          items_sent   = 0;
    int          steps_seen   = 0;
    int          clicks_seen  = 0;
    int          reads_sent   = 0;
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    int          hold_token   = 0;
    int          hold_seen    = 0;
    int          hold_left    = 0;
    logic [31:0] now_us       = 32'd0;

    dir_row_t dir_rows [27] = '{
        '{'{ACT_READ,   1'b0, 1'b0, 1'b1, 32'd0},        1'b1, '{DIR_NONE, 7'd0,   32'sd0,  1'b0}},
        '{'{ACT_ROTATE, 1'b0, 1'b0, 1'b1, 32'd1000},     1'b0, '0},
        '{'{ACT_ROTATE, 1'b1, 1'b0, 1'b0, 32'd2000},     1'b0, '0},
        '{'{ACT_ROTATE, 1'b1, 1'b1, 1'b1, 32'd24505000}, 1'b1, '{DIR_CW,   7'd100, 32'sd0,  1'b0}},
        '{'{ACT_ROTATE, 1'b0, 1'b0, 1'b0, 32'd24506000}, 1'b0, '0},
        '{'{ACT_ROTATE, 1'b0, 1'b1, 1'b1, 32'd24507000}, 1'b0, '0},
        '{'{ACT_ROTATE, 1'b1, 1'b1, 1'b0, 32'd24508000}, 1'b1, '{DIR_CCW,  7'd1,   32'sd0,  1'b0}},
        '{'{ACT_READ,   1'b1, 1'b1, 1'b1, 32'hFFFFFFFF}, 1'b1, '{DIR_NONE, 7'd0,   32'sd99, 1'b0}},
        '{'{ACT_ROTATE, 1'b0, 1'b1, 1'b1, 32'd30000000}, 1'b0, '0},
        '{'{ACT_ROTATE, 1'b0, 1'b0, 1'b1, 32'd30001000}, 1'b0, '0},
        '{'{ACT_ROTATE, 1'b1, 1'b1, 1'b1, 32'd30002000}, 1'b0, '0},
        '{'{ACT_ROTATE, 1'b1, 1'b0, 1'b1, 32'd30003000}, 1'b0, '0},
        '{'{ACT_ROTATE, 1'b0, 1'b0, 1'b1, 32'd30004000}, 1'b0, '0},
        '{'{ACT_ROTATE, 1'b1, 1'b1, 1'b1, 32'd30005000}, 1'b0, '0},
        '{'{ACT_SWITCH, 1'b0, 1'b0, 1'b0, 32'd1000000},  1'b0, '0},
        '{'{ACT_SWITCH, 1'b1, 1'b1, 1'b1, 32'd1010000},  1'b0, '0},
        '{'{ACT_READ,   1'b0, 1'b0, 1'b0, 32'd1020000},  1'b1, '{DIR_NONE, 7'd0,   32'sd0,  1'b0}},
        '{'{ACT_SWITCH, 1'b0, 1'b0, 1'b0, 32'd2000000},  1'b0, '0},
        '{'{ACT_SWITCH, 1'b0, 1'b0, 1'b1, 32'd2250000},  1'b0, '0},
        '{'{ACT_SWITCH, 1'b0, 1'b0, 1'b0, 32'd3000000},  1'b0, '0},
        '{'{ACT_SWITCH, 1'b0, 1'b0, 1'b1, 32'd3010001},  1'b0, '0},
        '{'{ACT_SWITCH, 1'b0, 1'b0, 1'b1, 32'd3249999},  1'b0, '0},
        '{'{ACT_READ,   1'b0, 1'b0, 1'b1, 32'd3300000},  1'b1, '{DIR_NONE, 7'd0,   32'sd0,  1'b1}},
        '{'{ACT_UNUSED, 1'b1, 1'b1, 1'b1, 32'hFFFFFFFF}, 1'b1, '{DIR_NONE, 7'd0,   32'sd0,  1'b0}},
        '{'{ACT_SWITCH, 1'b1, 1'b0, 1'b0, 32'hFFFFF000}, 1'b0, '0},
        '{'{ACT_SWITCH, 1'b0, 1'b1, 1'b1, 32'h00010000}, 1'b0, '0},
        '{'{ACT_READ,   1'b0, 1'b0, 1'b0, 32'h00020000}, 1'b1, '{DIR_NONE, 7'd0,   32'sd0,  1'b1}}
    };

    rotary_encoder_accel_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off, started in phase 4
    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    task automatic note_mismatch(input string what);
        if (mismatches < 40)
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    always @(posedge aclk) begin : check_results
        rea_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                note_mismatch("result with no request outstanding");
            end else begin
                want = expected_results.pop_front();
                if (m_data.step_direction !== want.step_direction)
                    note_mismatch($sformatf("step_direction %0d, want %0d",
                                            m_data.step_direction, want.step_direction));
                if (m_data.step_amount !== want.step_amount)
                    note_mismatch($sformatf("step_amount %0d, want %0d",
                                            m_data.step_amount, want.step_amount));
                if (m_data.count_value !== want.count_value)
                    note_mismatch($sformatf("count_value %0d, want %0d",
                                            m_data.count_value, want.count_value));
                if (m_data.clicked !== want.clicked)
                    note_mismatch($sformatf("clicked %0b, want %0b",
                                            m_data.clicked, want.clicked));
                if (want.step_direction != DIR_NONE)
                    steps_seen++;
                if (want.clicked)
                    clicks_seen++;
            end
        end
    end

    function automatic logic [6:0] step_size(input logic [31:0] d, input logic [7:0] spd);
        longint n;
        longint p;
        n = 64'sd24500000 * longint'({56'd0, spd})
          + (longint'({32'd0, d}) - 64'sd5000)
          * (longint'(REA_MAX_SPEED) - 64'sd100 * longint'({56'd0, spd}));
        p = longint'({52'd0, mult_q48}) * n;
        if (p <= DEN)
            return 7'd1;
        if (p >= 100 * DEN)
            return 7'd100;
        return 7'((2 * p + DEN) / (2 * DEN));
    endfunction

    function automatic rea_out_t predict_result(input rea_in_t req);
        rea_out_t    res;
        logic [2:0]  row;
        logic [7:0]  code;
        logic [31:0] d;
        res = '0;
        case (req.action)
            ACT_ROTATE: begin
                row  = (enc_state > 3'd5) ? 3'd0 : enc_state;
                code = DETENT_TABLE[row][{req.pin_b, req.pin_a}];
                enc_state = code[2:0];
                if (code == CODE_CW || code == CODE_CCW) begin
                    d = req.time_us - prev_step_us;
                    res.step_amount = accel_on ?
                        step_size(d, (code == CODE_CW) ? spd_cw : spd_ccw) : 7'd1;
                    if (code == CODE_CW) begin
                        res.step_direction = DIR_CW;
                        count_acc = count_acc + 32'(res.step_amount);
                    end else begin
                        res.step_direction = DIR_CCW;
                        count_acc = count_acc - 32'(res.step_amount);
                    end
                    prev_step_us = req.time_us;
                end
            end
            ACT_SWITCH: begin
                if (req.switch_level) begin
                    d = req.time_us - press_us;
                    if (d > 32'd10000 && d < 32'd250000)
                        click_flag = 1'b1;
                end else begin
                    press_us = req.time_us;
                end
            end
            ACT_READ: begin
                res.count_value = count_acc;
                res.clicked     = click_flag;
                count_acc  = '0;
                click_flag = 1'b0;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic rea_in_t make_req(input logic [1:0] act, input logic a, input logic b,
                                         input logic sw, input logic [31:0] t);
        rea_in_t req;
        req.action       = act;
        req.pin_a        = a;
        req.pin_b        = b;
        req.switch_level = sw;
        req.time_us      = t;
        return req;
    endfunction

    function automatic logic [31:0] next_gap();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(100, 5000);
            4, 5, 6:    return $urandom_range(5000, 300000);
            7, 8:       return $urandom_range(300000, 30000000);
            default:    return $urandom;
        endcase
    endfunction

    // offer one request; typed rows push the hand-written result, others the prediction
    task automatic offer(input rea_in_t req, input bit typed = 1'b0,
                         input rea_out_t want = '0);
        rea_out_t predicted;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_result(req);
        expected_results.push_back(typed ? want : predicted);
        items_sent++;
        if (req.action == ACT_READ)
            reads_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic load_config(input logic vse, input logic [7:0] down, input logic [7:0] up,
                               input logic [11:0] mult);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_VSE;
        cfg_data  <= CFG_W'(vse);
        @(posedge aclk);
        accel_on  = vse;
        cfg_index <= CFG_SPEED_DOWN;
        cfg_data  <= CFG_W'(down);
        @(posedge aclk);
        spd_ccw   = down;
        cfg_index <= CFG_SPEED_UP;
        cfg_data  <= CFG_W'(up);
        @(posedge aclk);
        spd_cw    = up;
        cfg_index <= CFG_MULT;
        cfg_data  <= mult;
        @(posedge aclk);
        mult_q48  = mult;
        cfg_we    <= 1'b0;
    endtask

    task automatic set_flow(input int mode);
        case (mode)
            0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1:       begin tx_idle_pct = 75; rx_stall_pct = 0;  end
            2:       begin tx_idle_pct = 0;  rx_stall_pct = 75; end
            default: begin tx_idle_pct = 29; rx_stall_pct = 29; end
        endcase
    endtask

    // one full detent: from any state pin code 0 lands in state 3, then mid and final edges
    task automatic rotate_detent(input bit cw);
        now_us = now_us + next_gap();
        offer(make_req(ACT_ROTATE, 1'b0, 1'b0, 1'($urandom), now_us));
        now_us = now_us + $urandom_range(50, 2000);
        offer(make_req(ACT_ROTATE, cw, !cw, 1'($urandom), now_us));
        if ($urandom_range(0, 9) == 0) begin
            now_us = now_us + $urandom_range(50, 2000);
            offer(make_req(ACT_ROTATE, 1'($urandom), 1'($urandom), 1'($urandom), now_us));
        end
        now_us = now_us + $urandom_range(50, 2000);
        offer(make_req(ACT_ROTATE, 1'b1, 1'b1, 1'($urandom), now_us));
    endtask

    task automatic click_attempt();
        logic [31:0] hold_us;
        case ($urandom_range(0, 7))
            0:       hold_us = 32'd10000;
            1:       hold_us = 32'd10001;
            2:       hold_us = 32'd249999;
            3:       hold_us = 32'd250000;
            4:       hold_us = $urandom_range(0, 10000);
            default: hold_us = $urandom_range(10000, 400000);
        endcase
        now_us = now_us + next_gap();
        offer(make_req(ACT_SWITCH, 1'($urandom), 1'($urandom), 1'b0, now_us));
        now_us = now_us + hold_us;
        offer(make_req(ACT_SWITCH, 1'($urandom), 1'($urandom), 1'b1, now_us));
    endtask

    task automatic random_burst();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            rotate_detent(1'($urandom));
        else if (pick < 68)
            offer(make_req(ACT_ROTATE, 1'($urandom), 1'($urandom), 1'($urandom),
                           now_us + next_gap()));
        else if (pick < 82)
            click_attempt();
        else if (pick < 93)
            offer(make_req(ACT_READ, 1'($urandom), 1'($urandom), 1'($urandom), $urandom));
        else if (pick < 98)
            offer(make_req(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                           1'($urandom), $urandom));
        else
            drain();
    endtask

    initial begin
        int phase_end;
        enc_state    = '0;
        count_acc    = '0;
        prev_step_us = '0;
        press_us     = '0;
        click_flag   = 1'b0;
        accel_on     = 1'b1;
        spd_ccw      = '0;
        spd_cw       = '0;
        mult_q48     = 12'd256;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph)
                0: load_config(1'b1, 8'd10, 8'd3, 12'd256);
                1: load_config(1'b0, 8'd0, 8'd0, 12'd0);
                2: load_config(1'b1, 8'd255, 8'd255, 12'd4095);
                3: load_config(1'b1, 8'd0, 8'd0, 12'd0);
                4: load_config(1'b1, 8'd0, 8'd255, 12'd4095);
                7: load_config(1'b1, 8'd5, 8'd5, 12'd256);
                default: load_config(1'($urandom), 8'($urandom), 8'($urandom),
                                     12'($urandom));
            endcase
            set_flow(ph % 4);
            if (ph == 4)
                hold_token++;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                random_burst();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("covered %0d requests: %0d steps, %0d reads, %0d clicks reported", items_sent,
                 steps_seen, reads_sent, clicks_seen);
        $display("8 register settings with idle, stall and hold-off phases; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
